// File: src/twqs_pkg.sv
// twqs_pkg: shared types for the three-way quicksort block
// holds the control word that the top level drives into the chain of cells
// no dependencies
`default_nettype none

package twqs_pkg;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;   // cells compare and pass the larger value on
        logic shift;    // cells take the neighbour's value from the right
    } twqs_ctl_t;

endpackage : twqs_pkg

`default_nettype wire

// File: src/twqs_cell.sv
// twqs_cell: one cell of the insertion chain, holds one value
// keeps the smaller of held and incoming value, passes the larger on
// depends on twqs_pkg
`default_nettype none

module twqs_cell
    import twqs_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire twqs_ctl_t             ctl,
    input  wire logic                  pass_in_valid,
    input  wire logic [DATA_WIDTH-1:0] pass_in_data,
    input  wire logic                  right_occ,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic                       pass_out_valid,
    output logic [DATA_WIDTH-1:0]      pass_out_data,
    output logic                       occ,
    output logic [DATA_WIDTH-1:0]      held_data
);

    logic                  occ_reg, occ_next;
    logic [DATA_WIDTH-1:0] held_reg, held_next;
    logic                  pv_reg, pv_next;
    logic [DATA_WIDTH-1:0] pd_reg, pd_next;

    always_comb begin
        occ_next  = occ_reg;
        held_next = held_reg;
        pv_next   = 1'b0;
        pd_next   = pd_reg;
        if (ctl.shift) begin
            occ_next  = right_occ;
            held_next = right_data;
        end else if (ctl.insert && pass_in_valid) begin
            if (!occ_reg) begin
                occ_next  = 1'b1;
                held_next = pass_in_data;
            end else if ($signed(pass_in_data) < $signed(held_reg)) begin
                held_next = pass_in_data;
                pv_next   = 1'b1;
                pd_next   = held_reg;
            end else begin
                pv_next   = 1'b1;
                pd_next   = pass_in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            pv_reg  <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            pv_reg  <= pv_next;
        end
        held_reg <= held_next;
        pd_reg   <= pd_next;
    end

    assign pass_out_valid = pv_reg;
    assign pass_out_data  = pd_reg;
    assign occ            = occ_reg;
    assign held_data      = held_reg;

endmodule : twqs_cell

`default_nettype wire

// File: src/twqs_chain.sv
// twqs_chain: row of sorting cells, smallest value ends up at the head
// words enter at the head and ripple right, one cell per cycle
// depends on twqs_pkg and twqs_cell
`default_nettype none

module twqs_chain
    import twqs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int MAX_ITEMS  = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire twqs_ctl_t             ctl,
    input  wire logic                  in_valid,
    input  wire logic [DATA_WIDTH-1:0] in_data,
    output logic [DATA_WIDTH-1:0]      head_data,
    output logic                       tail_spill
);

    logic                  pv  [MAX_ITEMS+1];
    logic [DATA_WIDTH-1:0] pd  [MAX_ITEMS+1];
    logic                  ocv [MAX_ITEMS+1];
    logic [DATA_WIDTH-1:0] hd  [MAX_ITEMS+1];

    assign pv[0]          = in_valid;
    assign pd[0]          = in_data;
    assign ocv[MAX_ITEMS] = 1'b0;
    assign hd[MAX_ITEMS]  = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        twqs_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (ctl),
            .pass_in_valid (pv[i]),
            .pass_in_data  (pd[i]),
            .right_occ     (ocv[i+1]),
            .right_data    (hd[i+1]),
            .pass_out_valid(pv[i+1]),
            .pass_out_data (pd[i+1]),
            .occ           (ocv[i]),
            .held_data     (hd[i])
        );
    end

    assign head_data = hd[0];
    // a word leaving the last cell would be lost; never happens when the count is kept
    assign tail_spill = pv[MAX_ITEMS] & (pd[MAX_ITEMS] == pd[MAX_ITEMS]);

endmodule : twqs_chain

`default_nettype wire

// File: src/three_way_quicksort_top.sv
// three_way_quicksort_top: batch sorter for signed values on stream ports
// loads a batch into a chain of insertion cells, then streams it out ascending
// depends on twqs_pkg, twqs_chain (and through it twqs_cell)
//
//  channel | direction | tdata                  | tlast        | tuser
//  s_axis  | in        | value                  | last         | -
//  m_axis  | out       | sorted_value           | final_res    | overflow
//
// load: one word per cycle while s_axis_tready is high; the chain inserts on the fly
// after the word marked last the chain settles in ST_DRAIN, then one sorted
// word per cycle leaves through the output register; s_axis_tready stays low until the
// last word of the batch has been popped, m_axis_tready stalls only the emit side
// words beyond MAX_ITEMS are dropped and every result of that batch carries overflow
// reset (aresetn low, synchronous) empties the cells and drops any pending output
`default_nettype none

module three_way_quicksort_top
    import twqs_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // slave side
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,  // value
    input  wire logic                                    s_axis_tlast,  // last
    // master side
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]              m_axis_tdata,  // sorted_value
    output logic                                         m_axis_tlast,  // final_res
    output logic                                         m_axis_tuser   // overflow
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;     // words held in the chain
    logic [CNT_W-1:0]      drain_reg;     // settle cycles left
    logic                  dropped_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_ovf_reg;

    twqs_ctl_t             ctl;
    logic                  in_accept;
    logic                  has_room;
    logic                  emit_shift;
    logic [DATA_WIDTH-1:0] head_data;
    logic                  tail_spill;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign has_room   = count_reg < CNT_W'(MAX_ITEMS);
    // in ST_EMIT while words remain, pop the head into the output register when it is free or being emptied
    assign emit_shift = (state_reg == ST_EMIT) && (count_reg != '0)
                        && (!out_valid_reg || m_axis_tready);

    assign ctl.insert = (state_reg != ST_EMIT);
    assign ctl.shift  = emit_shift;

    twqs_chain #(
        .DATA_WIDTH(DATA_WIDTH),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .in_valid  (in_accept && has_room && !tail_spill),
        .in_data   (s_axis_tdata[DATA_WIDTH-1:0]),
        .head_data (head_data),
        .tail_spill(tail_spill)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drain_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (in_accept) begin
                        if (has_room) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            state_reg <= ST_DRAIN;
                            drain_reg <= CNT_W'(MAX_ITEMS);
                        end
                    end
                end
                ST_DRAIN: begin
                    // words still rippling through the cells need this long at most
                    if (drain_reg == '0) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        drain_reg <= drain_reg - CNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (count_reg == '0) begin
                        state_reg   <= ST_LOAD;
                        dropped_reg <= 1'b0;
                    end else if (emit_shift) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (emit_shift) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        // output payload, no reset needed
        if (emit_shift) begin
            out_data_reg <= head_data;
            out_last_reg <= (count_reg == CNT_W'(1));
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule : three_way_quicksort_top

`default_nettype wire

// File: src/twqs_checker.sv
// twqs_checker: port-level checks for the three-way quicksort block
// bound to three_way_quicksort_top; needs only its ports and its TDATA_W
`default_nettype none

module twqs_checker #(
    parameter int TDATA_W = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic               s_axis_tlast,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic               m_axis_tlast,
    input  wire logic               m_axis_tuser
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // accepting the word marked last takes s_axis_tready low
    a_close_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after batch end");

    // while a batch is still being emitted no new word is taken
    a_emit_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("input open in mid batch output");

    // reset leaves no output pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule : twqs_checker

bind three_way_quicksort_top twqs_checker #(
    .TDATA_W(TDATA_W)
) u_twqs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// File: sim/three_way_quicksort_top_tb.sv
// three_way_quicksort_top_tb: self-checking bench for the batch sorter on stream ports
// sends batches of signed words, predicts the ascending output with its own sort and checks it
// depends on src/twqs_pkg.sv, src/three_way_quicksort_top.sv and its twqs_chain and twqs_cell
`default_nettype none

module three_way_quicksort_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2 * MAX_ITEMS + 20;

    typedef logic signed [DATA_WIDTH-1:0] sample_t;

    // one sorted word as the block should emit it
    typedef struct packed {
        sample_t sorted_value;
        logic    final_res;
        logic    overflow;
    } sorted_word_t;

    // keeps the batch being loaded in ascending order and the words still owed by the block
    class sort_scoreboard;
        sample_t      batch_q[$];
        bit           batch_dropped;
        sorted_word_t owed_q[$];
        int           errors;
        int           words_sent;
        int           batches_closed;
        int           overflow_batches;
        int           words_checked;

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // ordered insert keeps the batch sorted as it loads
        function void note_input(sample_t value, bit last);
            int idx;
            sorted_word_t w;
            words_sent++;
            if (batch_q.size() < MAX_ITEMS) begin
                idx = 0;
                while (idx < batch_q.size() && batch_q[idx] <= value)
                    idx++;
                batch_q.insert(idx, value);
            end else begin
                batch_dropped = 1'b1;
            end
            if (last) begin
                foreach (batch_q[k]) begin
                    w.sorted_value = batch_q[k];
                    w.final_res    = (k == batch_q.size() - 1);
                    w.overflow     = batch_dropped;
                    owed_q.push_back(w);
                end
                batches_closed++;
                if (batch_dropped)
                    overflow_batches++;
                batch_q.delete();
                batch_dropped = 1'b0;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task check_result(sample_t value, logic final_res, logic overflow);
            sorted_word_t w;
            words_checked++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected word %0d last=%0b user=%0b",
                                 value, final_res, overflow));
                return;
            end
            w = owed_q.pop_front();
            if (value !== w.sorted_value)
                report($sformatf("sorted_value %0d, expected %0d", value, w.sorted_value));
            if (final_res !== w.final_res)
                report($sformatf("tlast %b, expected %b (value %0d)",
                                 final_res, w.final_res, w.sorted_value));
            if (overflow !== w.overflow)
                report($sformatf("tuser %b, expected %b (value %0d)",
                                 overflow, w.overflow, w.sorted_value));
        endtask
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;     // value
    logic               s_axis_tlast  = 1'b0;   // last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;           // sorted_value
    logic               m_axis_tlast;           // final_res
    logic               m_axis_tuser;           // overflow

    sort_scoreboard sb = new();

    // when set, neither side inserts idle cycles
    bit      no_idle = 1'b0;
    int      cycle_cnt = 0;
    sample_t batch_vals[$];

    always #10 aclk = ~aclk;

    three_way_quicksort_top #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // one word into the slave side; valid stays high when the next word follows at once
    task send_word(sample_t value, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(value);
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(value, last);
    endtask

    // the whole of batch_vals, last word flagged
    task send_batch();
        foreach (batch_vals[k])
            send_word(batch_vals[k], k == batch_vals.size() - 1);
    endtask

    // hold the sender off until every owed word has come back
    task wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // half full-range values, the rest small ranges and extremes to force equal keys
    function sample_t draw_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sample_t'($urandom);
        if (pick < 8)
            return sample_t'($urandom_range(0, 15)) - 8;
        case ($urandom_range(0, 3))
            0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // master side: random stall before each word, sampled at the edge it is taken
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(sample_t'(m_axis_tdata[DATA_WIDTH-1:0]), m_axis_tlast,
                            m_axis_tuser);
        end
    end

    // watchdog on the cycle count
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycle_cnt, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int size;
        int rand_words;
        int b;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single word batch, field extremes, all equal, duplicates, reversed
        batch_vals = '{sample_t'(42)};
        send_batch();
        batch_vals = '{{1'b0, {(DATA_WIDTH-1){1'b1}}}, {1'b1, {(DATA_WIDTH-1){1'b0}}},
                       sample_t'(0), sample_t'(-1), sample_t'(1)};
        send_batch();
        no_idle = 1'b1;
        batch_vals = '{sample_t'(7), sample_t'(7), sample_t'(7), sample_t'(7)};
        send_batch();
        no_idle = 1'b0;
        batch_vals = '{sample_t'(-3), sample_t'(5), sample_t'(-3), sample_t'(5), sample_t'(0)};
        send_batch();
        batch_vals = '{sample_t'(4), sample_t'(3), sample_t'(2), sample_t'(1), sample_t'(0),
                       sample_t'(-1)};
        send_batch();
        wait_for_drain();

        // random batches: mostly small, one exactly full and one past capacity
        rand_words = 0;
        b = 0;
        while (rand_words < 220) begin
            if (b == 3)
                size = MAX_ITEMS;
            else if (b == 7)
                size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else
                size = $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 3) == 0);
            batch_vals.delete();
            repeat (size) batch_vals.push_back(draw_value());
            send_batch();
            rand_words += size;
            // sometimes let the block empty before the next batch, otherwise overlap
            if (b == 5 || $urandom_range(0, 4) == 0)
                wait_for_drain();
            b++;
        end
        no_idle = 1'b0;
        wait_for_drain();

        // anything emitted now is an extra word
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d batches (%0d past capacity), %0d words sent, %0d sorted words checked",
                 sb.batches_closed, sb.overflow_batches, sb.words_sent, sb.words_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d words never arrived", sb.errors, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule : three_way_quicksort_top_tb

`default_nettype wire
